>>> src/ehpd_pkg.sv
// ----------------------------------------------------------------------------
// ehpd_pkg
// Types, codes and helper functions shared by the encoded-pointer decoder.
// ----------------------------------------------------------------------------
package ehpd_pkg;

  localparam int VALUE_W   = 64;
  localparam int ADDR_W    = 64;
  localparam int CFG_IDX_W = 3;

  // encoding byte codes
  localparam logic [7:0] ENC_OMIT    = 8'hff;
  localparam logic [7:0] ENC_ALIGNED = 8'h50;
  localparam logic [6:0] LEB_BITS    = 7'h7f;
  localparam logic [7:0] FMT_MASK    = 8'h0f;

  // format nibble codes
  localparam logic [3:0] FMT_NATIVE = 4'd0;
  localparam logic [3:0] FMT_ULEB   = 4'd1;
  localparam logic [3:0] FMT_U16    = 4'd2;
  localparam logic [3:0] FMT_U32    = 4'd3;
  localparam logic [3:0] FMT_U64    = 4'd4;
  localparam logic [3:0] FMT_SLEB   = 4'd9;
  localparam logic [3:0] FMT_S16    = 4'd10;
  localparam logic [3:0] FMT_S32    = 4'd11;
  localparam logic [3:0] FMT_S64    = 4'd12;

  // base selector codes (encoding bits 6..4)
  localparam logic [2:0] BASE_PC   = 3'd1;
  localparam logic [2:0] BASE_TEXT = 3'd2;
  localparam logic [2:0] BASE_DATA = 3'd3;
  localparam logic [2:0] BASE_FUNC = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_ORDER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_BASE  = 3'd4;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               byte_taken;
    logic               done_res;
    logic               status;
  } result_t;

  function automatic logic fmt_known(input logic [3:0] fmt);
    fmt_known = (fmt <= FMT_U64) || ((fmt >= FMT_SLEB) && (fmt <= FMT_S64));
  endfunction

  // field length in bytes for the fixed formats
  function automatic logic [3:0] fixed_size(input logic [3:0] fmt, input logic wide);
    logic [3:0] n;
    n = 4'd8;
    if (fmt == FMT_NATIVE) begin
      n = wide ? 4'd8 : 4'd4;
    end else if (fmt == FMT_U16 || fmt == FMT_S16) begin
      n = 4'd2;
    end else if (fmt == FMT_U32 || fmt == FMT_S32) begin
      n = 4'd4;
    end
    fixed_size = n;
  endfunction

endpackage

>>> src/ehpd_in_if.sv
// ----------------------------------------------------------------------------
// ehpd_in_if
// Input channel of the pointer decoder: one stream byte per item.
// ----------------------------------------------------------------------------
interface ehpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   data_byte;
  logic [ehpd_pkg::ADDR_W-1:0]  byte_addr;
  logic                         start_req;
  logic [7:0]                   encoding;

  modport source (output valid, output data_byte, output byte_addr,
                  output start_req, output encoding, input ready);
  modport sink   (input valid, input data_byte, input byte_addr,
                  input start_req, input encoding, output ready);
endinterface

>>> src/ehpd_out_if.sv
// ----------------------------------------------------------------------------
// ehpd_out_if
// Result channel of the pointer decoder: one result item per input item.
// ----------------------------------------------------------------------------
interface ehpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ehpd_pkg::VALUE_W-1:0]  value;
  logic                          byte_taken;
  logic                          done_res;
  logic                          status;

  modport source (output valid, output value, output byte_taken,
                  output done_res, output status, input ready);
  modport sink   (input valid, input value, input byte_taken,
                  input done_res, input status, output ready);
endinterface

>>> src/ehpd_cfg_if.sv
// ----------------------------------------------------------------------------
// ehpd_cfg_if
// Register write channel of the pointer decoder.
// ----------------------------------------------------------------------------
interface ehpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ehpd_pkg::CFG_IDX_W-1:0]  index;
  logic [ehpd_pkg::VALUE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/eh_pointer_decoder.sv
// ----------------------------------------------------------------------------
// eh_pointer_decoder
// Decodes exception-frame encoded pointers from a byte stream.
// ----------------------------------------------------------------------------
// usage:
//   req  carries one stream byte per item with its address; an item with
//        start_req high also carries the encoding byte and opens a pointer
//   rsp  carries one result item per req item: byte_taken, done_res, and on
//        completion the decoded value and status (indirect encoding)
//   cfg  register writes (wide_mode, swap_order, text/data/func base),
//        always ready, to be written between pointers
// rsp valid follows in the cycle after req accept; while rsp does not stall
// one item is taken every cycle, set by the single decode step between the req
// handshake and result register (lead-in byte merge, sign extension, base add)
// when rsp stalls the result register holds and req accepts one more item
// only once the held result is taken or taken in the same cycle
// rst clears the decode state to idle, empties the result register and
// loads register defaults (wide_mode 1, everything else 0)
// ----------------------------------------------------------------------------
module eh_pointer_decoder (
  input logic         clk,
  input logic         rst,
  ehpd_in_if.sink     req,
  ehpd_out_if.source  rsp,
  ehpd_cfg_if.sink    cfg
);

  typedef enum logic [1:0] {PH_IDLE, PH_ALIGN, PH_READ} phase_t;

  // configuration registers
  logic                          wide_mode;
  logic                          swap_order;
  logic [ehpd_pkg::VALUE_W-1:0]  text_base;
  logic [ehpd_pkg::VALUE_W-1:0]  data_base;
  logic [ehpd_pkg::VALUE_W-1:0]  func_base;

  // decode state
  phase_t                        phase;
  logic [ehpd_pkg::VALUE_W-1:0]  accumulator;
  logic [6:0]                    shift_count;
  logic [3:0]                    bytes_seen;
  logic [ehpd_pkg::ADDR_W-1:0]   start_address;
  logic [7:0]                    held_encoding;

  phase_t                        phase_next;
  logic [ehpd_pkg::VALUE_W-1:0]  accumulator_next;
  logic [6:0]                    shift_count_next;
  logic [3:0]                    bytes_seen_next;
  logic [ehpd_pkg::ADDR_W-1:0]   start_address_next;
  logic [7:0]                    held_encoding_next;

  logic                          rsp_valid;
  ehpd_pkg::result_t             rsp_data;
  ehpd_pkg::result_t             res_next;

  logic                          req_fire;

  assign req.ready = !rsp_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.value      = rsp_data.value;
  assign rsp.byte_taken = rsp_data.byte_taken;
  assign rsp.done_res   = rsp_data.done_res;
  assign rsp.status     = rsp_data.status;

  always_comb begin
    logic                          go;
    logic                          fin;
    logic [3:0]                    fmt;
    logic [3:0]                    n;
    logic [2:0]                    align_mask;
    logic [ehpd_pkg::VALUE_W-1:0]  raw;
    logic [ehpd_pkg::VALUE_W-1:0]  base;
    logic [ehpd_pkg::VALUE_W-1:0]  sum;
    logic                          sgn;

    phase_next         = phase;
    accumulator_next   = accumulator;
    shift_count_next   = shift_count;
    bytes_seen_next    = bytes_seen;
    start_address_next = start_address;
    held_encoding_next = held_encoding;
    res_next           = '0;
    go                 = 1'b1;
    fin                = 1'b0;
    raw                = '0;
    base               = '0;
    sum                = '0;
    sgn                = 1'b0;
    n                  = '0;
    align_mask         = wide_mode ? 3'b111 : 3'b011;

    if (req.start_req) begin
      held_encoding_next = req.encoding;
      start_address_next = req.byte_addr;
      accumulator_next   = '0;
      shift_count_next   = '0;
      bytes_seen_next    = '0;
      if (req.encoding == ehpd_pkg::ENC_OMIT ||
          !ehpd_pkg::fmt_known(req.encoding[3:0])) begin
        // omitted pointer: zero at once, byte left in the stream
        phase_next        = PH_IDLE;
        res_next.done_res = 1'b1;
        go                = 1'b0;
      end else if (req.encoding == ehpd_pkg::ENC_ALIGNED) begin
        phase_next = PH_ALIGN;
      end else begin
        phase_next = PH_READ;
      end
    end else if (phase != PH_ALIGN && phase != PH_READ) begin
      phase_next = PH_IDLE;
      go         = 1'b0;
    end

    if (go && phase_next == PH_ALIGN) begin
      if ((req.byte_addr[2:0] & align_mask) != 3'b000) begin
        // padding byte
        res_next.byte_taken = 1'b1;
        go                  = 1'b0;
      end else begin
        phase_next = PH_READ;
      end
    end

    fmt = held_encoding_next[3:0] & ehpd_pkg::FMT_MASK[3:0];

    if (go) begin
      res_next.byte_taken = 1'b1;
      if (fmt == ehpd_pkg::FMT_ULEB || fmt == ehpd_pkg::FMT_SLEB) begin
        if (shift_count_next < 7'd64) begin
          accumulator_next = accumulator_next |
            ({57'b0, req.data_byte[6:0] & ehpd_pkg::LEB_BITS} << shift_count_next[5:0]);
          shift_count_next = shift_count_next + 7'd7;
        end
        if (!req.data_byte[7]) begin
          fin = 1'b1;
          raw = accumulator_next;
          if (fmt == ehpd_pkg::FMT_SLEB && shift_count_next < 7'd64 &&
              accumulator_next[shift_count_next[5:0] - 6'd1]) begin
            raw = raw | ({ehpd_pkg::VALUE_W{1'b1}} << shift_count_next[5:0]);
          end
        end
      end else begin
        n = ehpd_pkg::fixed_size(fmt, wide_mode);
        if (swap_order) begin
          accumulator_next = {accumulator_next[55:0], req.data_byte};
        end else begin
          accumulator_next = accumulator_next |
            ({56'b0, req.data_byte} << {bytes_seen_next[2:0], 3'b000});
        end
        bytes_seen_next = bytes_seen_next + 4'd1;
        if (bytes_seen_next >= n) begin
          fin = 1'b1;
          sgn = (fmt >= ehpd_pkg::FMT_S16);
          if (n == 4'd2) begin
            raw = {{48{sgn && accumulator_next[15]}}, accumulator_next[15:0]};
          end else if (n == 4'd4) begin
            raw = {{32{sgn && accumulator_next[31]}}, accumulator_next[31:0]};
          end else begin
            raw = accumulator_next;
          end
        end
      end
    end

    if (fin) begin
      phase_next        = PH_IDLE;
      res_next.done_res = 1'b1;
      if (raw != '0) begin
        unique case (held_encoding_next[6:4])
          ehpd_pkg::BASE_PC:   base = start_address_next;
          ehpd_pkg::BASE_TEXT: base = text_base;
          ehpd_pkg::BASE_DATA: base = data_base;
          ehpd_pkg::BASE_FUNC: base = func_base;
          default:             base = '0;
        endcase
        sum = raw + base;
        if (!wide_mode) begin
          sum[63:32] = '0;
        end
        res_next.value  = sum;
        res_next.status = held_encoding_next[7];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode     <= 1'b1;
      swap_order    <= 1'b0;
      text_base     <= '0;
      data_base     <= '0;
      func_base     <= '0;
      phase         <= PH_IDLE;
      accumulator   <= '0;
      shift_count   <= '0;
      bytes_seen    <= '0;
      start_address <= '0;
      held_encoding <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          ehpd_pkg::CFG_WIDE_MODE:  wide_mode  <= cfg.data[0];
          ehpd_pkg::CFG_SWAP_ORDER: swap_order <= cfg.data[0];
          ehpd_pkg::CFG_TEXT_BASE:  text_base  <= cfg.data;
          ehpd_pkg::CFG_DATA_BASE:  data_base  <= cfg.data;
          ehpd_pkg::CFG_FUNC_BASE:  func_base  <= cfg.data;
          default: ;
        endcase
      end
      if (req_fire) begin
        phase         <= phase_next;
        accumulator   <= accumulator_next;
        shift_count   <= shift_count_next;
        bytes_seen    <= bytes_seen_next;
        start_address <= start_address_next;
        held_encoding <= held_encoding_next;
        rsp_valid     <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register carries no reset
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_data <= res_next;
    end
  end

  // omitted pointer never reports a value or status
  a_omit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.done_res && !rsp.byte_taken |-> rsp.value == '0 && !rsp.status)
    else $error("omitted pointer with nonzero value or status");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status |-> rsp.done_res && rsp.byte_taken)
    else $error("status raised on an unfinished pointer");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    req_fire && !req.start_req && phase == PH_IDLE |=>
      rsp.valid && !rsp.byte_taken && !rsp.done_res && rsp.value == '0)
    else $error("idle item produced a nonzero result");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    shift_count <= 7'd70)
    else $error("leb shift count out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire && res_next.done_res |=> phase == PH_IDLE)
    else $error("decoder busy after a finished pointer");

endmodule

>>> sim/eh_pointer_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eh_pointer_decoder_test
// Streams encoded-pointer bytes through the decoder under random back
// pressure, predicts every result item and compares it field by field.
// Directed pointers first, then random traffic under several register
// settings.
// ----------------------------------------------------------------------------
module eh_pointer_decoder_test;

  typedef enum logic [1:0] {DEC_IDLE, DEC_ALIGN, DEC_READ} dec_phase_t;

  // base selector codes with no base, and an unassigned format code
  localparam logic [2:0] BASE_NONE = 3'd0;
  localparam logic [2:0] BASE_SKIP = 3'd5;
  localparam logic [3:0] FMT_SPARE = 4'd13;
  localparam int unsigned CFG_IDX_TOP = (1 << ehpd_pkg::CFG_IDX_W) - 1;

  logic clk;
  logic rst;

  ehpd_in_if  req_if ();
  ehpd_out_if rsp_if ();
  ehpd_cfg_if cfg_if ();

  eh_pointer_decoder u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // decoder shadow: registers and pointer state
  logic        wide_r;
  logic        swap_r;
  logic [63:0] text_r;
  logic [63:0] data_r;
  logic [63:0] func_r;
  dec_phase_t  ph;
  logic [63:0] acc;
  logic [6:0]  shift;
  logic [3:0]  seen;
  logic [63:0] start_addr;
  logic [7:0]  held_enc;

  ehpd_pkg::result_t decoded_q[$];
  int unsigned err_count;
  int unsigned stream_items;
  logic [63:0] cur_addr;
  logic        idle_on;
  logic        stall_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("eh_pointer_decoder_test: done, errors");
    $finish;
  end

  function automatic logic format_ok(input logic [3:0] f);
    case (f)
      ehpd_pkg::FMT_NATIVE, ehpd_pkg::FMT_ULEB, ehpd_pkg::FMT_U16,
      ehpd_pkg::FMT_U32, ehpd_pkg::FMT_U64, ehpd_pkg::FMT_SLEB,
      ehpd_pkg::FMT_S16, ehpd_pkg::FMT_S32, ehpd_pkg::FMT_S64: format_ok = 1'b1;
      default: format_ok = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] field_len(input logic [3:0] f);
    case (f)
      ehpd_pkg::FMT_NATIVE:                field_len = wide_r ? 4'd8 : 4'd4;
      ehpd_pkg::FMT_U16, ehpd_pkg::FMT_S16: field_len = 4'd2;
      ehpd_pkg::FMT_U32, ehpd_pkg::FMT_S32: field_len = 4'd4;
      default:                             field_len = 4'd8;
    endcase
  endfunction

  // base add, truncation and indirect flag for a completed pointer
  function automatic ehpd_pkg::result_t close_pointer(input logic [63:0] raw);
    ehpd_pkg::result_t r;
    logic [63:0] v;
    r = '0;
    v = raw;
    if (raw != 64'd0) begin
      case (held_enc[6:4])
        ehpd_pkg::BASE_PC:   v = v + start_addr;
        ehpd_pkg::BASE_TEXT: v = v + text_r;
        ehpd_pkg::BASE_DATA: v = v + data_r;
        ehpd_pkg::BASE_FUNC: v = v + func_r;
        default: ;
      endcase
      if (!wide_r) v[63:32] = 32'd0;
      r.status = held_enc[7];
    end
    ph = DEC_IDLE;
    r.value = v;
    r.byte_taken = 1'b1;
    r.done_res = 1'b1;
    return r;
  endfunction

  function automatic ehpd_pkg::result_t decode_byte(input logic [7:0] b,
                                                    input logic [63:0] a,
                                                    input logic s, input logic [7:0] e);
    ehpd_pkg::result_t r;
    logic [3:0] fmt;
    logic [3:0] n;
    logic [63:0] raw;
    logic [63:0] m;
    r = '0;
    if (s) begin
      held_enc = e;
      start_addr = a;
      acc = 64'd0;
      shift = 7'd0;
      seen = 4'd0;
      if (e == ehpd_pkg::ENC_OMIT || !format_ok(e[3:0])) begin
        ph = DEC_IDLE;
        r.done_res = 1'b1;
        return r;
      end
      ph = (e == ehpd_pkg::ENC_ALIGNED) ? DEC_ALIGN : DEC_READ;
    end else if (ph == DEC_IDLE) begin
      return r;
    end

    if (ph == DEC_ALIGN) begin
      if ((a & (wide_r ? 64'd7 : 64'd3)) != 64'd0) begin
        r.byte_taken = 1'b1;
        return r;
      end
      ph = DEC_READ;
    end

    fmt = held_enc[3:0];
    if (fmt == ehpd_pkg::FMT_ULEB || fmt == ehpd_pkg::FMT_SLEB) begin
      if (shift < 7'd64) begin
        acc = acc | ({57'd0, b[6:0]} << shift);
        shift = shift + 7'd7;
      end
      if (b[7]) begin
        r.byte_taken = 1'b1;
        return r;
      end
      raw = acc;
      if (fmt == ehpd_pkg::FMT_SLEB && shift < 7'd64 && raw[shift - 7'd1])
        raw = raw | (~64'd0 << shift);
      return close_pointer(raw);
    end

    n = field_len(fmt);
    if (swap_r) acc = {acc[55:0], b};
    else acc = acc | ({56'd0, b} << (8 * seen[2:0]));
    seen = seen + 4'd1;
    if (seen < n) begin
      r.byte_taken = 1'b1;
      return r;
    end
    raw = acc;
    if (n < 4'd8) begin
      m = (64'd1 << (8 * n)) - 64'd1;
      raw = raw & m;
      if (fmt >= ehpd_pkg::FMT_S16 && raw[8 * n - 1]) raw = raw | ~m;
    end
    return close_pointer(raw);
  endfunction

  // result side: random stalls, none once stall_on drops
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    ehpd_pkg::result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("result item with nothing pending: value %h", rsp_if.value);
        err_count++;
      end else begin
        want = decoded_q.pop_front();
        if (rsp_if.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp_if.value);
          err_count++;
        end
        if (rsp_if.byte_taken !== want.byte_taken) begin
          $error("byte_taken: expected %b, got %b", want.byte_taken, rsp_if.byte_taken);
          err_count++;
        end
        if (rsp_if.done_res !== want.done_res) begin
          $error("done_res: expected %b, got %b", want.done_res, rsp_if.done_res);
          err_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, rsp_if.status);
          err_count++;
        end
      end
    end
  end

  // leaves valid high on return; the caller sends again or calls wait_quiet
  task automatic send_byte(input logic [7:0] b, input logic [63:0] a,
                           input logic s, input logic [7:0] e);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    req_if.byte_addr <= a;
    req_if.start_req <= s;
    req_if.encoding  <= e;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    decoded_q.push_back(decode_byte(b, a, s, e));
  endtask

  task automatic wait_quiet();
    req_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ehpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      ehpd_pkg::CFG_WIDE_MODE:  wide_r = d[0];
      ehpd_pkg::CFG_SWAP_ORDER: swap_r = d[0];
      ehpd_pkg::CFG_TEXT_BASE:  text_r = d;
      ehpd_pkg::CFG_DATA_BASE:  data_r = d;
      ehpd_pkg::CFG_FUNC_BASE:  func_r = d;
      default: ;
    endcase
  endtask

  // all five registers plus one write to an unused index
  task automatic set_regs(input logic wide, input logic swap, input logic [63:0] tb,
                          input logic [63:0] db, input logic [63:0] fb);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[0] = wide;
    write_reg(ehpd_pkg::CFG_WIDE_MODE, d);
    d = {$urandom, $urandom};
    d[0] = swap;
    write_reg(ehpd_pkg::CFG_SWAP_ORDER, d);
    write_reg(ehpd_pkg::CFG_TEXT_BASE, tb);
    write_reg(ehpd_pkg::CFG_DATA_BASE, db);
    write_reg(ehpd_pkg::CFG_FUNC_BASE, fb);
    write_reg(3'($urandom_range(ehpd_pkg::CFG_FUNC_BASE + 1, CFG_IDX_TOP)),
              {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pointer();
    logic [7:0] enc;
    logic [7:0] bq[$];
    logic [7:0] b;
    logic [3:0] fmt;
    logic [63:0] amask;
    logic       ind;
    logic [2:0] bsel;
    int sel;
    int len;
    int fill;
    int cut;
    case ($urandom_range(0, 19))
      0, 1, 2: cur_addr = {$urandom, $urandom};
      3: begin
        cur_addr = '1;
        cur_addr[3:0] = 4'($urandom_range(0, 15));
      end
      4: begin
        cur_addr = {$urandom, 32'hffff_fff0};
        cur_addr[3:0] = 4'($urandom_range(0, 15));
      end
      default: ;
    endcase

    sel = $urandom_range(0, 9);
    ind = 1'($urandom_range(0, 1));
    bsel = 3'($urandom_range(0, 7));
    if (sel < 2) begin
      enc = 8'($urandom_range(0, 255));
    end else if (sel == 2) begin
      enc = ehpd_pkg::ENC_ALIGNED;
    end else begin
      case ($urandom_range(0, 8))
        0: fmt = ehpd_pkg::FMT_NATIVE;
        1: fmt = ehpd_pkg::FMT_ULEB;
        2: fmt = ehpd_pkg::FMT_U16;
        3: fmt = ehpd_pkg::FMT_U32;
        4: fmt = ehpd_pkg::FMT_U64;
        5: fmt = ehpd_pkg::FMT_SLEB;
        6: fmt = ehpd_pkg::FMT_S16;
        7: fmt = ehpd_pkg::FMT_S32;
        default: fmt = ehpd_pkg::FMT_S64;
      endcase
      enc = {ind, bsel, fmt};
    end
    fmt = enc[3:0];

    if (enc != ehpd_pkg::ENC_OMIT && format_ok(fmt)) begin
      amask = wide_r ? 64'd7 : 64'd3;
      if (enc == ehpd_pkg::ENC_ALIGNED) begin
        while (((cur_addr + bq.size()) & amask) != 64'd0)
          bq.push_back(8'($urandom_range(0, 255)));
      end
      fill = $urandom_range(0, 9);
      if (fmt == ehpd_pkg::FMT_ULEB || fmt == ehpd_pkg::FMT_SLEB) begin
        // occasionally run past 64 bits
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'h7f : 8'($urandom_range(0, 255));
          b[7] = (k != len - 1);
          bq.push_back(b);
        end
      end else begin
        len = int'(field_len(fmt));
        for (int k = 0; k < len; k++) begin
          b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom_range(0, 255));
          bq.push_back(b);
        end
      end
    end else begin
      bq.push_back(8'($urandom_range(0, 255)));
    end

    // broken pointer: cut short, the next start abandons it
    cut = bq.size();
    if (cut > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, cut - 1);
    for (int k = 0; k < cut; k++) begin
      send_byte(bq[k], cur_addr, k == 0, (k == 0) ? enc : 8'($urandom_range(0, 255)));
      cur_addr = cur_addr + 64'd1;
      stream_items++;
    end
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    target = stream_items + n;
    while (stream_items < target) begin
      if ($urandom_range(0, 11) == 0)
        send_byte(8'($urandom_range(0, 255)), {$urandom, $urandom}, 1'b0,
                  8'($urandom_range(0, 255)));
      send_pointer();
    end
    // close any pointer left open
    send_byte(8'($urandom_range(0, 255)), cur_addr, 1'b1, ehpd_pkg::ENC_OMIT);
  endtask

  task automatic test_idle_and_omit();
    send_byte(8'hff, 64'hffff_ffff_ffff_ffff, 1'b0, ehpd_pkg::ENC_OMIT);
    send_byte(8'h00, 64'h0, 1'b1, ehpd_pkg::ENC_OMIT);
    send_byte(8'h5a, 64'h1234, 1'b1, {1'b1, ehpd_pkg::BASE_TEXT, FMT_SPARE});
    // start while a 4-byte field is open
    send_byte(8'h11, 64'h2000, 1'b1, {1'b0, BASE_NONE, ehpd_pkg::FMT_U32});
    send_byte(8'h34, 64'h2001, 1'b1, {1'b0, BASE_SKIP, ehpd_pkg::FMT_U16});
    send_byte(8'h12, 64'h2002, 1'b0, 8'h00);
    wait_quiet();
  endtask

  task automatic test_leb_and_bases();
    set_regs(1'b1, 1'b0, '1, 64'h8000_0000_0000_0000, 64'h1);
    send_byte(8'h7f, 64'hffff_ffff_ffff_ff80, 1'b1,
              {1'b0, ehpd_pkg::BASE_PC, ehpd_pkg::FMT_ULEB});
    send_byte(8'h80, 64'h10, 1'b1, {1'b0, BASE_NONE, ehpd_pkg::FMT_SLEB});
    send_byte(8'h7f, 64'h11, 1'b0, 8'hff);
    // indirect on a zero field: no base, no status
    send_byte(8'h00, 64'h20, 1'b1, {1'b1, ehpd_pkg::BASE_TEXT, ehpd_pkg::FMT_U16});
    send_byte(8'h00, 64'h21, 1'b0, 8'h00);
    send_byte(8'hff, 64'h30, 1'b1, {1'b1, ehpd_pkg::BASE_DATA, ehpd_pkg::FMT_S16});
    send_byte(8'h80, 64'h31, 1'b0, 8'h00);
    wait_quiet();
  endtask

  task automatic test_aligned();
    for (int k = 0; k < 9; k++)
      send_byte(8'(k), 64'h7fff_ffff_ffff_fff7 + k, k == 0, ehpd_pkg::ENC_ALIGNED);
    wait_quiet();
    set_regs(1'b0, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    send_byte(8'haa, 64'h8000_0003, 1'b1, ehpd_pkg::ENC_ALIGNED);
    send_byte(8'h80, 64'h8000_0004, 1'b0, 8'h00);
    send_byte(8'h00, 64'h8000_0005, 1'b0, 8'h00);
    send_byte(8'h00, 64'h8000_0006, 1'b0, 8'h00);
    send_byte(8'h01, 64'h8000_0007, 1'b0, 8'h00);
    wait_quiet();
  endtask

  task automatic test_random_settings();
    set_regs(1'b0, 1'b0, 64'd0, 64'd0, 64'd0);
    run_traffic(350);
    wait_quiet();
    set_regs(1'b1, 1'b1, '1, '1, '1);
    run_traffic(350);
    wait_quiet();
    set_regs(1'b0, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_traffic(350);
    wait_quiet();
    set_regs(1'b1, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_traffic(350);
    wait_quiet();
    // last stretch at full rate
    idle_on = 1'b0;
    stall_on = 1'b0;
    set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    run_traffic(350);
    wait_quiet();
  endtask

  initial begin
    wide_r = 1'b1;
    swap_r = 1'b0;
    text_r = 64'd0;
    data_r = 64'd0;
    func_r = 64'd0;
    ph = DEC_IDLE;
    acc = 64'd0;
    shift = 7'd0;
    seen = 4'd0;
    start_addr = 64'd0;
    held_enc = 8'd0;
    err_count = 0;
    stream_items = 0;
    cur_addr = 64'h1000;
    idle_on = 1'b1;
    stall_on = 1'b1;

    rst <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.data_byte <= 8'd0;
    req_if.byte_addr <= 64'd0;
    req_if.start_req <= 1'b0;
    req_if.encoding  <= 8'd0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= 64'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_omit();
    test_leb_and_bases();
    test_aligned();
    test_random_settings();

    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("eh_pointer_decoder_test: done, clean");
    end else begin
      $display("eh_pointer_decoder_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ehpd_pkg.sv
src/ehpd_in_if.sv
src/ehpd_out_if.sv
src/ehpd_cfg_if.sv
src/eh_pointer_decoder.sv
sim/eh_pointer_decoder_test.sv
